// ===== rtl/drsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Draw record sort batcher package
// Shared item types, command and register codes, state encoding and the
// sort key helper used by the insertion cells.
// ----------------------------------------------------------------------------
`default_nettype none

package drsb_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned TEX_W    = 64;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned BASE_W   = 8;
  localparam int unsigned RUN_W    = 9;
  localparam int unsigned KEY_W    = 3 * FIELD_W + SLOT_W;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_MATERIAL_COUNT = 1'b0;

  localparam logic [FIELD_W-1:0] MATERIAL_COUNT_RESET = 16'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] layer;
    logic [FIELD_W-1:0] order_in_layer;
    logic [FIELD_W-1:0] material_id;
    logic [TEX_W-1:0]   texture_id;
    logic               world_space;
  } cmd_item_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_vertex;
    logic               new_run;
    logic [RUN_W-1:0]   run_first_index;
    logic [FIELD_W-1:0] out_material;
    logic [SLOT_W-1:0]  out_texture_slot;
    logic               out_world_space;
    logic               last;
    logic               empty_res;
    logic               dropped;
  } res_item_t;

  // One stored record: sort key fields first, then the tag fields.
  typedef struct packed {
    logic [FIELD_W-1:0] layer;
    logic [FIELD_W-1:0] order_in_layer;
    logic [FIELD_W-1:0] material;
    logic [SLOT_W-1:0]  slot;
    logic               world;
    logic [IDX_W-1:0]   arrival;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic rot;
    rec_t new_rec;
  } sort_ctrl_t;

  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] wslot;
    logic [TEX_W-1:0]  wdata;
    logic [TEX_W-1:0]  query;
  } tex_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TDEC,
    ST_INS,
    ST_DRAIN
  } st_t;

  function automatic logic [KEY_W-1:0] rec_key(rec_t r);
    rec_key = {r.layer, r.order_in_layer, r.material, r.slot};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/drsb_sort_cell.sv =====
// ----------------------------------------------------------------------------
// Sort chain cell
// Holds one record of the sorted store. On insert it keeps its record, takes
// the new one or takes its left neighbor's; on drain it rotates one step.
// ----------------------------------------------------------------------------
`default_nettype none

module drsb_sort_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic               clk,
  input  wire drsb_pkg::sort_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]   count,
  input  wire drsb_pkg::rec_t     left_rec,
  input  wire logic               left_gt,
  input  wire drsb_pkg::rec_t     right_rec,
  input  wire drsb_pkg::rec_t     head_rec,
  output drsb_pkg::rec_t          rec,
  output logic                    gt
);
  import drsb_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic occ;
  logic at_end;
  logic is_tail;
  rec_t rec_next;

  assign occ     = MY_POS < count;
  assign at_end  = MY_POS == count;
  assign is_tail = MY_NEXT == count;
  assign gt      = occ && (rec_key(rec) > rec_key(ctrl.new_rec));

  always_comb begin
    rec_next = rec;
    if (ctrl.ins && (gt || at_end)) begin
      rec_next = left_gt ? left_rec : ctrl.new_rec;
    end else if (ctrl.rot && occ) begin
      rec_next = is_tail ? head_rec : right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

`default_nettype wire

// ===== rtl/drsb_tex_cell.sv =====
// ----------------------------------------------------------------------------
// Texture slot cell
// Holds the texture id of one slot and compares it with the queried id.
// ----------------------------------------------------------------------------
`default_nettype none

module drsb_tex_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned TCNT_W = 7
) (
  input  wire logic                clk,
  input  wire drsb_pkg::tex_ctrl_t ctrl,
  input  wire logic [TCNT_W-1:0]   slot_count,
  output logic                     hit
);
  import drsb_pkg::*;

  localparam logic [TCNT_W-1:0] MY_POS  = TCNT_W'(IDX);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [TEX_W-1:0] tex_id;

  assign hit = (MY_POS < slot_count) && (tex_id == ctrl.query);

  always_ff @(posedge clk) begin
    if (ctrl.wr && (ctrl.wslot == MY_SLOT)) begin
      tex_id <= ctrl.wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/draw_record_sort_batcher.sv =====
// ----------------------------------------------------------------------------
// Draw record sort batcher
// Collects quad records, keeps them sorted by layer, order, material and
// texture slot in a chain of insertion cells, and drains them in key order
// with draw run boundaries marked.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Carries
//  --------  ------------------------------------  ---------  -------------------
//  command   cmd_valid, cmd_stall, cmd_item        into block begin, push, drain
//  result    res_valid, res_stall, res_item        out        one item per record, or one empty item
//  config    psel, penable, pwrite, paddr, pwdata  into block material_count
//            prdata, pready                        out
//
// A begin item is handled as it is accepted. A push passes three steps: the
// texture id is matched against all slot cells as the item is accepted,
// ST_TDEC picks or allocates the slot, and ST_INS inserts the record into
// the sort chain. A push dropped after a drain or with the store full ends
// at acceptance, and one dropped because the slot table is full ends in
// ST_TDEC. A drain gives one result per cycle while res_stall is low; the
// chain rotates by one cell per result, so after count results the store
// is back in sorted order for a repeated drain. Reset (rst, synchronous)
// empties the store and sets material_count to 3. A stalled result holds
// the chain where it is; command items are not taken until the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module draw_record_sort_batcher #(
  parameter int unsigned MAX_RECORDS  = 64,
  parameter int unsigned MAX_TEXTURES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // command channel
  input  wire logic                        cmd_valid,
  output logic                             cmd_stall,
  input  wire drsb_pkg::cmd_item_t         cmd_item,
  // result channel
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output drsb_pkg::res_item_t              res_item,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [drsb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [drsb_pkg::DATA_W-1:0] pwdata,
  output logic      [drsb_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import drsb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int unsigned TCNT_W = $clog2(MAX_TEXTURES + 1);
  localparam logic [CNT_W-1:0]  REC_FULL = CNT_W'(MAX_RECORDS);
  localparam logic [TCNT_W-1:0] TEX_FULL = TCNT_W'(MAX_TEXTURES);

  // Control state.
  st_t                state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [TCNT_W-1:0]  slot_count, slot_count_next;
  logic               drained, drained_next;
  logic               drop, drop_next;
  logic [FIELD_W-1:0] mat_count;
  logic               res_valid_next;

  // Payload state.
  rec_t               rec_new, rec_new_next;
  logic [TEX_W-1:0]   tex_q, tex_q_next;
  logic [MAX_TEXTURES-1:0] hit_q;
  logic [IDX_W-1:0]   drain_i, drain_i_next;
  logic [FIELD_W-1:0] prev_mat, prev_mat_next;
  logic [SLOT_W-1:0]  prev_slot, prev_slot_next;
  logic               prev_world, prev_world_next;
  logic [RUN_W-1:0]   run_first, run_first_next;
  res_item_t          res_next;

  // Chain interconnect.
  sort_ctrl_t              sctrl;
  tex_ctrl_t               tctrl;
  rec_t                    rec_arr [MAX_RECORDS];
  logic [MAX_RECORDS-1:0]  gt_arr;
  logic [MAX_TEXTURES-1:0] hit;

  logic               cmd_acc;
  logic               out_free;
  logic               cfg_wr;
  logic               hit_any;
  logic [SLOT_W-1:0]  hit_slot;
  logic               tex_alloc;
  logic [RUN_W-1:0]   pos_x6;
  logic               run_start;

  assign cmd_stall = state != ST_IDLE;
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATERIAL_COUNT);
  assign prdata = (paddr[2] == REG_MATERIAL_COUNT) ? DATA_W'(mat_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_count <= MATERIAL_COUNT_RESET;
    end else if (cfg_wr) begin
      mat_count <= pwdata[FIELD_W-1:0];
    end
  end

  // Texture slot cells. Ids in the table are unique, so at most one cell hits
  // and the slot number is an OR over the hit positions.
  assign tctrl.wr    = tex_alloc;
  assign tctrl.wslot = SLOT_W'(slot_count);
  assign tctrl.wdata = tex_q;
  assign tctrl.query = cmd_item.texture_id;

  for (genvar t = 0; t < MAX_TEXTURES; t++) begin : g_tex
    drsb_tex_cell #(
      .IDX    (t),
      .TCNT_W (TCNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (tctrl),
      .slot_count (slot_count),
      .hit        (hit[t])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      hit_q <= hit;
    end
  end

  always_comb begin
    hit_slot = '0;
    for (int j = 0; j < MAX_TEXTURES; j++) begin
      if (hit_q[j]) begin
        hit_slot = hit_slot | SLOT_W'(j);
      end
    end
  end

  assign hit_any   = |hit_q;
  assign tex_alloc = (state == ST_TDEC) && !hit_any && (slot_count < TEX_FULL);

  // Sort chain. Cell 0 is the head; a drain step moves every occupied cell
  // one place toward the head and wraps the head record to the tail.
  assign sctrl.ins     = state == ST_INS;
  assign sctrl.rot     = (state == ST_DRAIN) && out_free && (count != '0);
  assign sctrl.new_rec = rec_new;

  for (genvar c = 0; c < MAX_RECORDS; c++) begin : g_sort
    rec_t left_rec;
    logic left_gt;
    rec_t right_rec;

    if (c == 0) begin : g_first
      assign left_rec = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_rec = rec_arr[c-1];
      assign left_gt  = gt_arr[c-1];
    end

    if (c == MAX_RECORDS - 1) begin : g_lastc
      assign right_rec = '0;
    end else begin : g_body
      assign right_rec = rec_arr[c+1];
    end

    drsb_sort_cell #(
      .IDX   (c),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (sctrl),
      .count     (count),
      .left_rec  (left_rec),
      .left_gt   (left_gt),
      .right_rec (right_rec),
      .head_rec  (rec_arr[0]),
      .rec       (rec_arr[c]),
      .gt        (gt_arr[c])
    );
  end

  // Run bookkeeping for the record leaving the head cell.
  assign pos_x6    = RUN_W'({drain_i, 2'b00}) + RUN_W'({drain_i, 1'b0});
  assign run_start = (drain_i == '0) || (rec_arr[0].material != prev_mat) ||
                     (rec_arr[0].slot != prev_slot) || (rec_arr[0].world != prev_world);

  // Sequencer: next state and next register values.
  always_comb begin
    state_next      = state;
    count_next      = count;
    slot_count_next = slot_count;
    drained_next    = drained;
    drop_next       = drop;
    rec_new_next    = rec_new;
    tex_q_next      = tex_q;
    drain_i_next    = drain_i;
    prev_mat_next   = prev_mat;
    prev_slot_next  = prev_slot;
    prev_world_next = prev_world;
    run_first_next  = run_first;
    res_next        = res_item;
    res_valid_next  = res_valid && res_stall;

    case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd_item.cmd)
            CMD_BEGIN: begin
              count_next      = '0;
              slot_count_next = '0;
              drained_next    = 1'b0;
              drop_next       = 1'b0;
            end
            CMD_PUSH: begin
              if (drained || (count >= REC_FULL)) begin
                drop_next = 1'b1;
              end else begin
                rec_new_next.layer          = cmd_item.layer;
                rec_new_next.order_in_layer = cmd_item.order_in_layer;
                rec_new_next.material       = (cmd_item.material_id < mat_count) ?
                                              cmd_item.material_id : '0;
                rec_new_next.slot           = '0;
                rec_new_next.world          = cmd_item.world_space;
                rec_new_next.arrival        = IDX_W'(count);
                tex_q_next                  = cmd_item.texture_id;
                state_next                  = ST_TDEC;
              end
            end
            CMD_DRAIN: begin
              drained_next = 1'b1;
              drain_i_next = '0;
              state_next   = ST_DRAIN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_TDEC: begin
        if (hit_any) begin
          rec_new_next.slot = hit_slot;
          state_next        = ST_INS;
        end else if (tex_alloc) begin
          rec_new_next.slot = SLOT_W'(slot_count);
          slot_count_next   = slot_count + TCNT_W'(1);
          state_next        = ST_INS;
        end else begin
          drop_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_INS: begin
        count_next = count + CNT_W'(1);
        state_next = ST_IDLE;
      end

      ST_DRAIN: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          res_next       = '0;
          res_next.dropped = drop;
          if (count == '0) begin
            res_next.last      = 1'b1;
            res_next.empty_res = 1'b1;
            state_next         = ST_IDLE;
          end else begin
            res_next.base_vertex      = {rec_arr[0].arrival, 2'b00};
            res_next.new_run          = run_start;
            res_next.run_first_index  = run_start ? pos_x6 : run_first;
            res_next.out_material     = rec_arr[0].material;
            res_next.out_texture_slot = rec_arr[0].slot;
            res_next.out_world_space  = rec_arr[0].world;
            res_next.last             = CNT_W'(drain_i) == (count - CNT_W'(1));
            run_first_next            = run_start ? pos_x6 : run_first;
            prev_mat_next             = rec_arr[0].material;
            prev_slot_next            = rec_arr[0].slot;
            prev_world_next           = rec_arr[0].world;
            drain_i_next              = drain_i + IDX_W'(1);
            if (res_next.last) begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      slot_count <= '0;
      drained    <= 1'b0;
      drop       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      slot_count <= slot_count_next;
      drained    <= drained_next;
      drop       <= drop_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rec_new    <= rec_new_next;
    tex_q      <= tex_q_next;
    drain_i    <= drain_i_next;
    prev_mat   <= prev_mat_next;
    prev_slot  <= prev_slot_next;
    prev_world <= prev_world_next;
    run_first  <= run_first_next;
    res_item   <= res_next;
  end

endmodule

`default_nettype wire
